/* rtl/rtt_pkg.sv */
// Shared types and codes of the retransmit tracker.
// Used by rtt_ctrl, rtt_datapath and retransmit_tracker_unit; no dependencies.
`default_nettype none

package rtt_pkg;

   localparam int DEPTH_DEFAULT = 16;

   // Request modes, carried in req_tuser.
   localparam logic [1:0] MODE_ENQ   = 2'd0;
   localparam logic [1:0] MODE_ACK   = 2'd1;
   localparam logic [1:0] MODE_SCAN  = 2'd2;
   localparam logic [1:0] MODE_RSYNC = 2'd3;

   // Response kinds, carried in rsp_tuser.
   localparam logic [3:0] KIND_QUEUED    = 4'd0;
   localparam logic [3:0] KIND_FULL      = 4'd1;
   localparam logic [3:0] KIND_ACK_HIT   = 4'd2;
   localparam logic [3:0] KIND_ACK_MISS  = 4'd3;
   localparam logic [3:0] KIND_RESEND    = 4'd4;
   localparam logic [3:0] KIND_MISSED    = 4'd5;
   localparam logic [3:0] KIND_RS_START  = 4'd6;
   localparam logic [3:0] KIND_RS_BUSY   = 4'd7;
   localparam logic [3:0] KIND_RS_OK     = 4'd8;
   localparam logic [3:0] KIND_RS_FAIL   = 4'd9;

   // Source of the sequence number in a generated response.
   localparam logic [1:0] SEQ_SEL_ZERO  = 2'd0;
   localparam logic [1:0] SEQ_SEL_INPUT = 2'd1;
   localparam logic [1:0] SEQ_SEL_SLOT  = 2'd2;

   // Configuration register indexes.
   localparam logic REG_RETRY_LIMIT    = 1'b0;
   localparam logic REG_RETRY_INTERVAL = 1'b1;

   typedef struct packed {
      logic       load;        // capture the request beat, rewind the slot counter
      logic       idx_inc;     // step to the next slot
      logic       wr_enq;      // write a new entry into the current slot
      logic       wr_resend;   // bump retries and deadline of the current slot
      logic       clr_valid;   // free the current slot
      logic       gen;         // produce a response into the holding register
      logic [3:0] gen_kind;
      logic [1:0] gen_seq_sel;
      logic       gen_slot_idx; // report the current slot, else slot zero
      logic       push_last;   // move the held response out as the final one
      logic       out_inc;     // one more resync message outstanding
      logic       out_dec;     // one resync message finished
      logic       missed_bump;
      logic       rsync_start;
      logic       rsync_end;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       item_rs;     // the request's resync flag
      logic       slot_vld;
      logic       seq_match;
      logic       expired;
      logic       at_limit;
      logic       slot_rs;
      logic       idx_last;
      logic       held_vld;    // a response waits in the holding register
      logic       out_free;    // the output register can take a beat this cycle
      logic       run_active;
      logic       rs_done;     // finishing one resync entry completes the run
      logic       missed_nz;
   } status_type;

endpackage

`default_nettype wire

/* rtl/retransmit_tracker_unit.sv */
// Top level of the retransmit tracker: joins the sequencer and the datapath.
// Depends on rtt_pkg, rtt_ctrl and rtt_datapath.
//
// Use: requests arrive as beats on the req_ channel, one at a time. Mode 0
// enqueues a sent message, mode 1 acks one, mode 2 scans for expired entries
// at time now, mode 3 starts a resync run. Each request yields zero or more
// response beats on the rsp_ channel, the final one flagged by rsp_tlast; a
// scan with nothing expired yields none.
// Timing: each request visits slots in order, reading each slot and then evaluating
// it, limited by the registered read of the entry memory. An enqueue or ack stops at
// the slot that settles it, and an ack of a resync entry adds the RSDONE step; a scan
// walks every slot and adds the RSDONE step per missed resync entry; a resync start
// goes straight to its response.
// The final beat becomes valid in the cycle the next request can be taken.
// When the receiver stalls and a second response is ready, the walk pauses
// until the output register frees; the final beat waits for it the same way.
// Reset empties all slots, clears the resync state and loads the retry limit
// with 3 and the retry interval with 2; no clearing pass is needed.
// Configuration writes on csr_ are taken in any cycle and should be made
// while no request is in flight.
`default_nettype none

module retransmit_tracker_unit
   import rtt_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,   // seq [31:0], now [63:32]
   input  wire logic [2:0]   req_tuser,   // mode [1:0], resync flag [2]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [39:0]       rsp_tdata,   // seq_out [31:0], slot [35:32], zeros above
   output logic [3:0]        rsp_tuser,   // kind [3:0]
   output logic              rsp_tlast,
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic [15:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   rtt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser[1:0]),
      .status     (status),
      .cmd        (cmd)
   );

   rtt_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire

/* rtl/rtt_datapath.sv */
// Slot storage, counters, response holding and output registers of the tracker.
// Depends on rtt_pkg; driven by rtt_ctrl through cmd_type, reports status_type.
`default_nettype none

module rtt_datapath
   import rtt_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [63:0]  req_tdata,
   input  wire logic [2:0]   req_tuser,
   input  wire logic         rsp_tready,
   output logic              rsp_tvalid,
   output logic [39:0]       rsp_tdata,
   output logic [3:0]        rsp_tuser,
   output logic              rsp_tlast,
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic [15:0]  csr_wdata,
   input  wire cmd_type      cmd,
   output status_type        status
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [31:0] seq;
      logic [3:0]  retries;
      logic [31:0] deadline;
      logic        rs;
   } entry_type;

   logic [3:0]  limit_ff, limit_in;
   logic [15:0] interval_ff, interval_in;

   logic [1:0]  mode_ff;
   logic [31:0] seq_ff;
   logic        rs_ff;
   logic [31:0] now_ff;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [QUEUE_DEPTH-1:0] valid_ff, valid_in;

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_ff;
   entry_type wr_entry;
   logic      wr_en;

   logic        run_active_ff, run_active_in;
   logic [4:0]  outst_ff, outst_in;
   logic [15:0] missed_ff, missed_in;

   logic        held_vld_ff, held_vld_in;
   logic [3:0]  held_kind_ff;
   logic [31:0] held_seq_ff;
   logic [3:0]  held_slot_ff;

   logic        out_vld_ff, out_vld_in;
   logic [3:0]  out_kind_ff;
   logic [31:0] out_seq_ff;
   logic [3:0]  out_slot_ff;
   logic        out_last_ff;

   logic [31:0] new_deadline;
   logic [31:0] gen_seq;
   logic        out_free;
   logic        out_load;

   // Configuration registers.
   always_comb begin
      limit_in    = limit_ff;
      interval_in = interval_ff;
      if (csr_we) begin
         case (csr_index)
            REG_RETRY_LIMIT:    limit_in    = csr_wdata[3:0];
            REG_RETRY_INTERVAL: interval_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= 4'd3;
         interval_ff <= 16'd2;
      end else begin
         limit_ff    <= limit_in;
         interval_ff <= interval_in;
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_tuser[1:0];
         rs_ff   <= req_tuser[2];
         seq_ff  <= req_tdata[31:0];
         now_ff  <= req_tdata[63:32];
      end
   end

   // Slot counter and valid bits.
   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
      valid_in = valid_ff;
      if (cmd.wr_enq) begin
         valid_in[idx_ff] = 1'b1;
      end else if (cmd.clr_valid) begin
         valid_in[idx_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= '0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Entry memory: one write port, one registered read at the slot counter.
   assign new_deadline = now_ff + {16'd0, interval_ff};

   always_comb begin
      wr_en    = cmd.wr_enq || cmd.wr_resend;
      wr_entry = rd_ff;
      if (cmd.wr_enq) begin
         wr_entry.seq      = seq_ff;
         wr_entry.retries  = 4'd0;
         wr_entry.deadline = new_deadline;
         wr_entry.rs       = rs_ff;
      end else begin
         wr_entry.retries  = rd_ff.retries + 4'd1;
         wr_entry.deadline = new_deadline;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff] <= wr_entry;
      end
      rd_ff <= mem[idx_ff];
   end

   // Resync run bookkeeping.
   always_comb begin
      run_active_in = run_active_ff;
      outst_in      = outst_ff;
      missed_in     = missed_ff;
      if (cmd.rsync_start) begin
         run_active_in = 1'b1;
         outst_in      = 5'd0;
         missed_in     = 16'd0;
      end else begin
         if (cmd.rsync_end) begin
            run_active_in = 1'b0;
         end
         if (cmd.out_inc && outst_ff != 5'd31) begin
            outst_in = outst_ff + 5'd1;
         end else if (cmd.out_dec && outst_ff != 5'd0) begin
            outst_in = outst_ff - 5'd1;
         end
         if (cmd.missed_bump && missed_ff != 16'hFFFF) begin
            missed_in = missed_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_active_ff <= 1'b0;
         outst_ff      <= 5'd0;
         missed_ff     <= 16'd0;
      end else begin
         run_active_ff <= run_active_in;
         outst_ff      <= outst_in;
         missed_ff     <= missed_in;
      end
   end

   // A response is held back one step so that the final one of an item can be
   // marked; the previous held response goes out when the next one arrives.
   assign out_free = !out_vld_ff || rsp_tready;
   assign out_load = (cmd.gen && held_vld_ff) || cmd.push_last;

   always_comb begin
      case (cmd.gen_seq_sel)
         SEQ_SEL_INPUT: gen_seq = seq_ff;
         SEQ_SEL_SLOT:  gen_seq = rd_ff.seq;
         default:       gen_seq = 32'd0;
      endcase
      held_vld_in = held_vld_ff;
      if (cmd.gen) begin
         held_vld_in = 1'b1;
      end else if (cmd.push_last) begin
         held_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (out_load) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         held_vld_ff <= held_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.gen) begin
         held_kind_ff <= cmd.gen_kind;
         held_seq_ff  <= gen_seq;
         held_slot_ff <= cmd.gen_slot_idx ? 4'(idx_ff) : 4'd0;
      end
      if (out_load) begin
         out_kind_ff <= held_kind_ff;
         out_seq_ff  <= held_seq_ff;
         out_slot_ff <= held_slot_ff;
         out_last_ff <= cmd.push_last;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {4'd0, out_slot_ff, out_seq_ff};
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      status.mode       = mode_ff;
      status.item_rs    = rs_ff;
      status.slot_vld   = valid_ff[idx_ff];
      status.seq_match  = rd_ff.seq == seq_ff;
      status.expired    = rd_ff.deadline <= now_ff;
      status.at_limit   = rd_ff.retries >= limit_ff;
      status.slot_rs    = rd_ff.rs;
      status.idx_last   = idx_ff == IDX_W'(QUEUE_DEPTH - 1);
      status.held_vld   = held_vld_ff;
      status.out_free   = out_free;
      status.run_active = run_active_ff;
      status.rs_done    = run_active_ff && (outst_ff <= 5'd1);
      status.missed_nz  = missed_ff != 16'd0;
   end

endmodule

`default_nettype wire

/* rtl/rtt_ctrl.sv */
// Sequencer of the tracker: walks the slots for each request and issues commands.
// Depends on rtt_pkg; steers rtt_datapath through cmd_type and status_type.
`default_nettype none

module rtt_ctrl
   import rtt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_mode,
   input  wire status_type  status,
   output cmd_type          cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_EVAL   = 3'd2;
   localparam logic [2:0] ST_RSDONE = 3'd3;
   localparam logic [2:0] ST_RSYNC  = 3'd4;
   localparam logic [2:0] ST_FLUSH  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [2:0] state_go;
   cmd_type    raw;
   logic       stall;

   assign req_tready = state_ff == ST_IDLE;

   always_comb begin
      raw      = '0;
      state_go = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               raw.load = 1'b1;
               state_go = (req_mode == MODE_RSYNC) ? ST_RSYNC : ST_READ;
            end
         end
         ST_READ: begin
            state_go = ST_EVAL;
         end
         ST_EVAL: begin
            case (status.mode)
               MODE_ENQ: begin
                  if (!status.slot_vld) begin
                     raw.gen          = 1'b1;
                     raw.gen_kind     = KIND_QUEUED;
                     raw.gen_seq_sel  = SEQ_SEL_INPUT;
                     raw.gen_slot_idx = 1'b1;
                     raw.wr_enq       = 1'b1;
                     raw.out_inc      = status.item_rs;
                     state_go         = ST_FLUSH;
                  end else if (status.idx_last) begin
                     raw.gen         = 1'b1;
                     raw.gen_kind    = KIND_FULL;
                     raw.gen_seq_sel = SEQ_SEL_INPUT;
                     raw.missed_bump = status.item_rs;
                     state_go        = ST_FLUSH;
                  end else begin
                     raw.idx_inc = 1'b1;
                     state_go    = ST_READ;
                  end
               end
               MODE_ACK: begin
                  if (status.slot_vld && status.seq_match) begin
                     raw.gen          = 1'b1;
                     raw.gen_kind     = KIND_ACK_HIT;
                     raw.gen_seq_sel  = SEQ_SEL_INPUT;
                     raw.gen_slot_idx = 1'b1;
                     raw.clr_valid    = 1'b1;
                     state_go         = status.slot_rs ? ST_RSDONE : ST_FLUSH;
                  end else if (status.idx_last) begin
                     raw.gen         = 1'b1;
                     raw.gen_kind    = KIND_ACK_MISS;
                     raw.gen_seq_sel = SEQ_SEL_INPUT;
                     state_go        = ST_FLUSH;
                  end else begin
                     raw.idx_inc = 1'b1;
                     state_go    = ST_READ;
                  end
               end
               default: begin
                  // Scan: only the resync start mode never reaches this state.
                  if (status.slot_vld && status.expired) begin
                     raw.gen          = 1'b1;
                     raw.gen_seq_sel  = SEQ_SEL_SLOT;
                     raw.gen_slot_idx = 1'b1;
                     if (status.at_limit) begin
                        raw.gen_kind  = KIND_MISSED;
                        raw.clr_valid = 1'b1;
                     end else begin
                        raw.gen_kind  = KIND_RESEND;
                        raw.wr_resend = 1'b1;
                     end
                  end
                  if (status.slot_vld && status.expired && status.at_limit
                      && status.slot_rs) begin
                     raw.missed_bump = 1'b1;
                     state_go        = ST_RSDONE;
                  end else if (status.idx_last) begin
                     state_go = ST_FLUSH;
                  end else begin
                     raw.idx_inc = 1'b1;
                     state_go    = ST_READ;
                  end
               end
            endcase
         end
         ST_RSDONE: begin
            raw.out_dec = 1'b1;
            if (status.rs_done) begin
               raw.gen         = 1'b1;
               raw.gen_kind    = status.missed_nz ? KIND_RS_FAIL : KIND_RS_OK;
               raw.gen_seq_sel = SEQ_SEL_ZERO;
               raw.rsync_end   = 1'b1;
            end
            if (status.mode == MODE_SCAN && !status.idx_last) begin
               raw.idx_inc = 1'b1;
               state_go    = ST_READ;
            end else begin
               state_go = ST_FLUSH;
            end
         end
         ST_RSYNC: begin
            raw.gen         = 1'b1;
            raw.gen_seq_sel = SEQ_SEL_ZERO;
            if (status.run_active) begin
               raw.gen_kind = KIND_RS_BUSY;
            end else begin
               raw.gen_kind    = KIND_RS_START;
               raw.rsync_start = 1'b1;
            end
            state_go = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (!status.held_vld) begin
               state_go = ST_IDLE;
            end else if (status.out_free) begin
               raw.push_last = 1'b1;
               state_go      = ST_IDLE;
            end
         end
         default: begin
            state_go = ST_IDLE;
         end
      endcase
   end

   // A new response displaces the held one, which needs room at the output.
   assign stall = raw.gen && status.held_vld && !status.out_free;

   always_comb begin
      if (stall) begin
         cmd      = '0;
         state_in = state_ff;
      end else begin
         cmd      = raw;
         state_in = state_go;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* tb/rtt_response_check.sv */
// Response checker of the retransmit tracker: predicts the response beats of every
// accepted request from its own copy of the slot table and compares them in order.
// Depends on rtt_pkg; instantiated beside the block by retransmit_tracker_unit_tb.
`default_nettype none

module rtt_response_check
   import rtt_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [63:0] req_tdata,   // seq [31:0], now [63:32]
   input  wire logic [2:0]  req_tuser,   // mode [1:0], resync flag [2]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,   // seq_out [31:0], slot [35:32], zeros above
   input  wire logic [3:0]  rsp_tuser,   // kind [3:0]
   input  wire logic        rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata,
   output int               mismatch_count,
   output int               beats_awaited
);

   localparam logic [3:0]  LIMIT_AT_RESET    = 4'd3;
   localparam logic [15:0] INTERVAL_AT_RESET = 16'd2;

   typedef struct {
      logic [3:0]  kind;
      logic [31:0] seq;
      logic [3:0]  slot;
      logic        last;
   } rsp_beat_type;

   rsp_beat_type expected_beats[$];

   logic        slot_used  [DEPTH];
   logic [31:0] slot_seqno [DEPTH];
   logic [3:0]  slot_tries [DEPTH];
   logic [31:0] slot_due   [DEPTH];
   logic        slot_rs    [DEPTH];
   logic        resync_active;
   logic [4:0]  rs_pending;
   logic [15:0] rs_missed;
   logic [3:0]  cfg_limit;
   logic [15:0] cfg_interval;

   function automatic rsp_beat_type make_beat(input logic [3:0] kind,
                                              input logic [31:0] seq, input int idx);
      rsp_beat_type b;
      b.kind = kind;
      b.seq  = seq;
      b.slot = idx[3:0];
      b.last = 1'b0;
      return b;
   endfunction

   task automatic bump_missed();
      if (rs_missed != 16'hFFFF) rs_missed = rs_missed + 16'd1;
   endtask

   // One resync entry is done; the run completes once none is outstanding.
   task automatic finish_resync_entry(ref rsp_beat_type beats[$]);
      if (rs_pending != 5'd0) rs_pending = rs_pending - 5'd1;
      if (resync_active && rs_pending == 5'd0) begin
         resync_active = 1'b0;
         beats.push_back(make_beat((rs_missed != 16'd0) ? KIND_RS_FAIL : KIND_RS_OK,
                                   32'd0, 0));
      end
   endtask

   task automatic predict_request(input logic [1:0] mode, input logic [31:0] seq,
                                  input logic rs, input logic [31:0] now);
      rsp_beat_type beats[$];
      int           hit;
      hit = -1;
      case (mode)
         MODE_ENQ: begin
            for (int i = DEPTH - 1; i >= 0; i--)
               if (!slot_used[i]) hit = i;
            if (hit < 0) begin
               if (rs) bump_missed();
               beats.push_back(make_beat(KIND_FULL, seq, 0));
            end else begin
               slot_used[hit]  = 1'b1;
               slot_seqno[hit] = seq;
               slot_tries[hit] = 4'd0;
               slot_due[hit]   = now + 32'(cfg_interval);
               slot_rs[hit]    = rs;
               if (rs && rs_pending != 5'd31) rs_pending = rs_pending + 5'd1;
               beats.push_back(make_beat(KIND_QUEUED, seq, hit));
            end
         end
         MODE_ACK: begin
            for (int i = DEPTH - 1; i >= 0; i--)
               if (slot_used[i] && slot_seqno[i] == seq) hit = i;
            if (hit < 0) begin
               beats.push_back(make_beat(KIND_ACK_MISS, seq, 0));
            end else begin
               slot_used[hit] = 1'b0;
               beats.push_back(make_beat(KIND_ACK_HIT, seq, hit));
               if (slot_rs[hit]) finish_resync_entry(beats);
            end
         end
         MODE_SCAN: begin
            for (int i = 0; i < DEPTH; i++) begin
               if (slot_used[i] && slot_due[i] <= now) begin
                  if (slot_tries[i] >= cfg_limit) begin
                     slot_used[i] = 1'b0;
                     beats.push_back(make_beat(KIND_MISSED, slot_seqno[i], i));
                     if (slot_rs[i]) begin
                        bump_missed();
                        finish_resync_entry(beats);
                     end
                  end else begin
                     slot_tries[i] = slot_tries[i] + 4'd1;
                     slot_due[i]   = now + 32'(cfg_interval);
                     beats.push_back(make_beat(KIND_RESEND, slot_seqno[i], i));
                  end
               end
            end
         end
         default: begin
            if (resync_active) begin
               beats.push_back(make_beat(KIND_RS_BUSY, 32'd0, 0));
            end else begin
               resync_active = 1'b1;
               rs_pending    = 5'd0;
               rs_missed     = 16'd0;
               beats.push_back(make_beat(KIND_RS_START, 32'd0, 0));
            end
         end
      endcase
      if (beats.size() > 0) beats[beats.size() - 1].last = 1'b1;
      foreach (beats[k]) expected_beats.push_back(beats[k]);
   endtask

   task automatic check_beat();
      rsp_beat_type want;
      string        want_s;
      string        got_s;
      got_s = $sformatf("kind %0d seq %h slot %0d last %0b pad %h", rsp_tuser,
                        rsp_tdata[31:0], rsp_tdata[35:32], rsp_tlast, rsp_tdata[39:36]);
      if (expected_beats.size() == 0) begin
         mismatch_count++;
         $display("%0t: unexpected rsp beat, expected none, got %s", $time, got_s);
      end else begin
         want = expected_beats.pop_front();
         if (rsp_tuser !== want.kind || rsp_tdata[31:0] !== want.seq ||
             rsp_tdata[35:32] !== want.slot || rsp_tdata[39:36] !== 4'd0 ||
             rsp_tlast !== want.last) begin
            mismatch_count++;
            want_s = $sformatf("kind %0d seq %h slot %0d last %0b pad 0", want.kind,
                               want.seq, want.slot, want.last);
            $display("%0t: rsp beat expected %s, got %s", $time, want_s, got_s);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
         resync_active  = 1'b0;
         rs_pending     = 5'd0;
         rs_missed      = 16'd0;
         cfg_limit      = LIMIT_AT_RESET;
         cfg_interval   = INTERVAL_AT_RESET;
         mismatch_count = 0;
         expected_beats.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == REG_RETRY_LIMIT) cfg_limit = csr_wdata[3:0];
            else cfg_interval = csr_wdata;
         end
         // A beat leaving now cannot belong to a request taken at this same edge.
         if (rsp_tvalid && rsp_tready) check_beat();
         if (req_tvalid && req_tready)
            predict_request(req_tuser[1:0], req_tdata[31:0], req_tuser[2],
                            req_tdata[63:32]);
      end
      beats_awaited = expected_beats.size();
   end

endmodule

`default_nettype wire

/* tb/retransmit_tracker_unit_tb.sv */
// Testbench top of the retransmit tracker: clock, reset, request stimulus, receiver
// back-pressure and the verdict. Depends on rtt_pkg, retransmit_tracker_unit and
// rtt_response_check, which predicts and compares the response beats.
`default_nettype none

module retransmit_tracker_unit_tb;
   import rtt_pkg::*;

   localparam int  DRAIN_CYCLES = 80;
   localparam int  LIMIT_CYCLES = 400000;
   localparam int  HOLD_CYCLES  = 300;
   localparam int  ITEMS_PER_PHASE = 46;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   int          mismatch_count;
   int          beats_awaited;
   int          cycle_count = 0;
   int          send_gap_pct = 0;
   int          stall_pct = 0;
   bit          hold_request = 1'b0;
   bit          hold_done = 1'b0;
   int          hold_left = 0;
   logic [31:0] tick;
   logic [15:0] cur_interval;
   logic [31:0] sent_seqs[$];

   int          phase_limit   [4] = '{1, 15, 0, 7};
   int          phase_interval[4] = '{3, 1, 65535, 100};
   int          phase_gap     [4] = '{0, 61, 0, 9};
   int          phase_stall   [4] = '{0, 0, 61, 9};

   retransmit_tracker_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   rtt_response_check checker_inst (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count), .beats_awaited(beats_awaited)
   );

   always #10 clock = ~clock;

   // Receiver: random stalls, or one long hold-off when the stimulus asks for it.
   always @(negedge clock) begin
      if (hold_request && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("retransmit_tracker_unit: mismatch");
      $finish;
   end

   // Called just after a falling edge; returns just after the falling edge that
   // follows acceptance, with req_tvalid still high.
   task automatic send_req(input logic [1:0] mode, input logic [31:0] seq,
                           input logic rs, input logic [31:0] now);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {now, seq};
      req_tuser  <= {rs, mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   // Drops valid, waits for every predicted beat, then lets a scan with no
   // response finish its walk.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (beats_awaited != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic send_random_item();
      int          pick;
      int          k;
      logic [31:0] seqv;
      pick = $urandom_range(99);
      if (pick < 35) begin
         seqv = $urandom();
         sent_seqs.push_back(seqv);
         if (sent_seqs.size() > 40) void'(sent_seqs.pop_front());
         tick = tick + $urandom_range(3);
         send_req(MODE_ENQ, seqv, ($urandom_range(99) < 35), tick);
      end else if (pick < 60) begin
         if (sent_seqs.size() > 0) begin
            k = $urandom_range(sent_seqs.size() - 1);
            seqv = sent_seqs[k];
            sent_seqs.delete(k);
         end else begin
            seqv = $urandom();
         end
         send_req(MODE_ACK, seqv, 1'($urandom_range(1)), $urandom());
      end else if (pick < 85) begin
         tick = tick + $urandom_range(2 * int'(cur_interval));
         send_req(MODE_SCAN, $urandom(), 1'($urandom_range(1)), tick);
      end else if (pick < 90) begin
         send_req(MODE_RSYNC, $urandom(), 1'($urandom_range(1)), $urandom());
      end else begin
         // Noise: any mode with unrelated content.
         send_req(2'($urandom_range(3)), $urandom(), 1'($urandom_range(1)), $urandom());
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_index  = REG_RETRY_LIMIT;
      csr_wdata  = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: resync start and busy, a deadline that wraps, a full table with
      // a dropped resync message, duplicate sequence numbers, an unmatched ack and
      // a scan that finds nothing expired.
      send_req(MODE_RSYNC, 32'd0, 1'b0, 32'd0);
      send_req(MODE_RSYNC, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      send_req(MODE_ENQ, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      for (int i = 1; i <= 14; i++) send_req(MODE_ENQ, i, 1'b0, 32'd10);
      send_req(MODE_ENQ, 32'd5, 1'b0, 32'd10);
      send_req(MODE_ENQ, 32'd0, 1'b1, 32'd0);
      send_req(MODE_ACK, 32'h1234_5678, 1'b0, 32'd0);
      send_req(MODE_ACK, 32'd5, 1'b0, 32'd0);
      send_req(MODE_SCAN, 32'd0, 1'b0, 32'd0);
      send_req(MODE_SCAN, 32'd0, 1'b0, 32'd1);
      wait_idle();

      // Limit zero misses every expired entry and ends the run in failure; a
      // fresh run whose only message is acked ends in success.
      write_reg(REG_RETRY_LIMIT, 16'd0);
      write_reg(REG_RETRY_INTERVAL, 16'hFFFF);
      send_req(MODE_SCAN, 32'd0, 1'b0, 32'hFFFF_FFFF);
      send_req(MODE_RSYNC, 32'd0, 1'b0, 32'd0);
      send_req(MODE_ENQ, 32'hA5A5_A5A5, 1'b1, 32'd0);
      send_req(MODE_ACK, 32'hA5A5_A5A5, 1'b0, 32'd0);
      wait_idle();

      for (int p = 0; p < 4; p++) begin
         write_reg(REG_RETRY_LIMIT, 16'(phase_limit[p]));
         write_reg(REG_RETRY_INTERVAL, 16'(phase_interval[p]));
         cur_interval = 16'(phase_interval[p]);
         send_gap_pct = phase_gap[p];
         stall_pct    = phase_stall[p];
         tick = $urandom();
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 0 && n == 10) hold_request = 1'b1;
            send_random_item();
         end
         wait_idle();
         send_gap_pct = 0;
         stall_pct    = 0;
      end

      if (mismatch_count == 0) begin
         $display("retransmit_tracker_unit: match");
      end else begin
         $display("retransmit_tracker_unit: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* retransmit_tracker_unit.f */
rtl/rtt_pkg.sv
rtl/rtt_datapath.sv
rtl/rtt_ctrl.sv
rtl/retransmit_tracker_unit.sv
tb/rtt_response_check.sv
tb/retransmit_tracker_unit_tb.sv
